@@ src/edc_pkg.sv @@
// Shared types, constants and helper functions for the event end date calculator.
package edc_pkg;

  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [10:0] mod_t;
  typedef logic [14:0] dur_t;
  typedef logic [30:0] color_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;

  localparam int NSTG = 9;

  localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
  localparam logic [5:0]  MIN_PER_HOUR = 6'd60;
  localparam color_t      DELETED_COLOR = 31'd2;

  localparam int          DAYQ_SH = 26;
  localparam logic [15:0] DAYQ_K  = 16'(((64'd1 << DAYQ_SH) + 64'd1439) / 64'd1440);
  localparam int          HOUR_SH = 17;
  localparam logic [11:0] HOUR_K  = 12'(((64'd1 << HOUR_SH) + 64'd59) / 64'd60);

  localparam int          Y100_SH = 21;
  localparam logic [14:0] Y100_K  = 15'(((64'd1 << Y100_SH) + 64'd99) / 64'd100);
  localparam int          Y400_SH = 23;
  localparam logic [14:0] Y400_K  = 15'(((64'd1 << Y400_SH) + 64'd399) / 64'd400);
  localparam logic [14:0] YEAR_SHIFT = 15'd400;
  localparam logic [23:0] DAYS_PER_YEAR = 24'd365;
  localparam logic [24:0] DN_BIAS = 25'd146403;
  localparam logic signed [24:0] DN_MIN = 25'sd1;
  localparam logic signed [24:0] DN_MAX = 25'sd3652059;
  localparam logic [24:0] ZP_OFS  = 25'd305;

  localparam int          ERA_SH   = 39;
  localparam logic [21:0] ERA_K    = 22'(((64'd1 << ERA_SH) + 64'd146096) / 64'd146097);
  localparam logic [17:0] ERA_DAYS = 18'd146097;
  localparam logic [17:0] DOE_LAST = 18'd146096;
  localparam int          D1460_SH = 28;
  localparam logic [17:0] D1460_K  = 18'(((64'd1 << D1460_SH) + 64'd1459) / 64'd1460);
  localparam int          D36524_SH = 33;
  localparam logic [17:0] D36524_K  = 18'(((64'd1 << D36524_SH) + 64'd36523) / 64'd36524);
  localparam int          D365_SH  = 26;
  localparam logic [17:0] D365_K   = 18'(((64'd1 << D365_SH) + 64'd364) / 64'd365);
  localparam int          YOE100_SH = 16;
  localparam logic [9:0]  YOE100_K  = 10'(((64'd1 << YOE100_SH) + 64'd99) / 64'd100);
  localparam int          MP_SH = 19;
  localparam logic [11:0] MP_K  = 12'(((64'd1 << MP_SH) + 64'd152) / 64'd153);

  localparam year_t  YEAR_MAX  = 14'd9999;
  localparam month_t MONTH_MAX = 4'd12;
  localparam day_t   DAY_MAX   = 5'd31;
  localparam year_t  YEAR_MIN  = 14'd1;
  localparam month_t MONTH_MIN = 4'd1;
  localparam day_t   DAY_MIN   = 5'd1;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctl_t;

  typedef struct packed {
    hour_t   begin_hour;
    minute_t begin_minute;
    hour_t   end_hour;
    minute_t end_minute;
  } time_res_t;

  typedef struct packed {
    logic   sat_hi;
    logic   sat_lo;
    logic   nocarry;
    year_t  sy;
    month_t sm;
    day_t   sd;
  } side_t;

  typedef struct packed {
    logic [21:0] zp;
    logic [43:0] ep;
    side_t       side;
  } fwd_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } date_t;

  // Days from March 1 to the first of a month, months counted from March as 3.
  function automatic logic [8:0] day_offset(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd13:   r = 9'd306;
      4'd14:   r = 9'd337;
      4'd15:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/edc_if.sv @@
// Handshake interfaces for the event word and the result word.
interface edc_in_if import edc_pkg::*; ();
  logic   valid;
  logic   ready;
  year_t  start_year;
  month_t start_month;
  day_t   start_day;
  mod_t   start_minute_of_day;
  dur_t   duration_minutes;
  color_t event_color;

  modport source (output valid, output start_year, output start_month, output start_day,
                  output start_minute_of_day, output duration_minutes, output event_color,
                  input ready);
  modport sink (input valid, input start_year, input start_month, input start_day,
                input start_minute_of_day, input duration_minutes, input event_color,
                output ready);
endinterface

interface edc_out_if import edc_pkg::*; ();
  logic    valid;
  logic    ready;
  hour_t   begin_hour;
  minute_t begin_minute;
  year_t   end_year;
  month_t  end_month;
  day_t    end_day;
  hour_t   end_hour;
  minute_t end_minute;

  modport source (output valid, output begin_hour, output begin_minute, output end_year,
                  output end_month, output end_day, output end_hour, output end_minute,
                  input ready);
  modport sink (input valid, input begin_hour, input begin_minute, input end_year,
                input end_month, input end_day, input end_hour, input end_minute,
                output ready);
endinterface

@@ src/edc_ctrl.sv @@
// Valid bits and per-stage load enables of the pipeline.
module edc_ctrl import edc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_live,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    ctl.en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ctl.en[i] = !v_r[i] || ctl.en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ctl.en[0]) begin
      v_nxt[0] = in_valid && in_live;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (ctl.en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ctl.en[0];
  assign out_valid = v_r[NSTG-1];

endmodule

@@ src/edc_time.sv @@
// Minute arithmetic: day carry, start hour and minute, end hour and minute.
module edc_time import edc_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  mod_t      smin,
  input  dur_t      dur,
  output logic [4:0] carry,
  output time_res_t res
);

  logic [15:0] total0_r, total0_nxt;
  logic [31:0] qp0_r, qp0_nxt;
  mod_t        s0_r, s0_nxt;

  mod_t        eod1_r, eod1_nxt;
  logic [22:0] bp1_r, bp1_nxt;
  mod_t        s1_r;

  hour_t       bh2_r, bh2_nxt;
  minute_t     bm2_r, bm2_nxt;
  logic [22:0] ep2_r, ep2_nxt;
  mod_t        eod2_r;

  time_res_t   tr_nxt;
  time_res_t   tr_r [3:8];

  always_comb begin
    total0_nxt = 16'(smin) + 16'(dur);
    qp0_nxt    = 32'(total0_nxt) * 32'(DAYQ_K);
    s0_nxt     = (smin >= MIN_PER_DAY) ? smin - MIN_PER_DAY : smin;
  end

  assign carry = qp0_r[DAYQ_SH +: 5];

  always_comb begin
    eod1_nxt = 11'(total0_r - 16'(carry) * 16'(MIN_PER_DAY));
    bp1_nxt  = 23'(s0_r) * 23'(HOUR_K);
  end

  always_comb begin
    bh2_nxt = bp1_r[HOUR_SH +: 5];
    bm2_nxt = 6'(s1_r - 11'(bh2_nxt) * 11'(MIN_PER_HOUR));
    ep2_nxt = 23'(eod1_r) * 23'(HOUR_K);
  end

  always_comb begin
    tr_nxt.begin_hour   = bh2_r;
    tr_nxt.begin_minute = bm2_r;
    tr_nxt.end_hour     = ep2_r[HOUR_SH +: 5];
    tr_nxt.end_minute   = 6'(eod2_r - 11'(tr_nxt.end_hour) * 11'(MIN_PER_HOUR));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      total0_r <= total0_nxt;
      qp0_r    <= qp0_nxt;
      s0_r     <= s0_nxt;
    end
    if (ctl.en[1]) begin
      eod1_r <= eod1_nxt;
      bp1_r  <= bp1_nxt;
      s1_r   <= s0_r;
    end
    if (ctl.en[2]) begin
      bh2_r  <= bh2_nxt;
      bm2_r  <= bm2_nxt;
      ep2_r  <= ep2_nxt;
      eod2_r <= eod1_r;
    end
    if (ctl.en[3]) begin
      tr_r[3] <= tr_nxt;
    end
    for (int i = 4; i <= 8; i++) begin
      if (ctl.en[i]) begin
        tr_r[i] <= tr_r[i-1];
      end
    end
  end

  assign res = tr_r[8];

endmodule

@@ src/edc_fwd.sv @@
// Start date plus day carry to a day number, with range checks and era product.
module edc_fwd import edc_pkg::*; (
  input  logic       clk,
  input  pipe_ctl_t  ctl,
  input  year_t      sy,
  input  month_t     sm,
  input  day_t       sd,
  input  logic [4:0] carry,
  output fwd_t       f
);

  logic        adj0;
  logic [14:0] yy0_r, yy0_nxt;
  logic [23:0] y365_0_r, y365_0_nxt;
  logic [29:0] p100_0_r, p100_0_nxt;
  logic [29:0] p400_0_r, p400_0_nxt;
  logic [8:0]  off0_r, off0_nxt;
  year_t       sy0_r;
  month_t      sm0_r;
  day_t        sd0_r;

  logic signed [24:0] dn1_r, dn1_nxt;
  logic               nc1_r;
  year_t              sy1_r;
  month_t             sm1_r;
  day_t               sd1_r;

  logic [21:0] zp2;
  fwd_t        f_r, f_nxt;

  // January and February count as months 13 and 14 of the year before.
  always_comb begin
    adj0       = sm < 4'd3;
    yy0_nxt    = 15'(sy) + YEAR_SHIFT - 15'(adj0);
    y365_0_nxt = 24'(yy0_nxt) * DAYS_PER_YEAR;
    p100_0_nxt = 30'(yy0_nxt) * 30'(Y100_K);
    p400_0_nxt = 30'(yy0_nxt) * 30'(Y400_K);
    off0_nxt   = day_offset(adj0 ? sm + 4'd12 : sm);
  end

  always_comb begin
    dn1_nxt = 25'(y365_0_r) + 25'(yy0_r >> 2) + 25'(p400_0_r[Y400_SH +: 6])
            + 25'(off0_r) + 25'(sd0_r) + 25'(carry)
            - 25'(p100_0_r[Y100_SH +: 8]) - DN_BIAS;
  end

  always_comb begin
    zp2                = 22'(dn1_r + ZP_OFS);
    f_nxt.zp           = zp2;
    f_nxt.ep           = 44'(zp2) * 44'(ERA_K);
    f_nxt.side.sat_hi  = dn1_r > DN_MAX;
    f_nxt.side.sat_lo  = dn1_r < DN_MIN;
    f_nxt.side.nocarry = nc1_r;
    f_nxt.side.sy      = sy1_r;
    f_nxt.side.sm      = sm1_r;
    f_nxt.side.sd      = sd1_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      yy0_r    <= yy0_nxt;
      y365_0_r <= y365_0_nxt;
      p100_0_r <= p100_0_nxt;
      p400_0_r <= p400_0_nxt;
      off0_r   <= off0_nxt;
      sy0_r    <= sy;
      sm0_r    <= sm;
      sd0_r    <= sd;
    end
    if (ctl.en[1]) begin
      dn1_r <= dn1_nxt;
      nc1_r <= carry == 5'd0;
      sy1_r <= sy0_r;
      sm1_r <= sm0_r;
      sd1_r <= sd0_r;
    end
    if (ctl.en[2]) begin
      f_r <= f_nxt;
    end
  end

  assign f = f_r;

endmodule

@@ src/edc_inv.sv @@
// Day number back to a Gregorian date, then range and no-carry selection.
module edc_inv import edc_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  fwd_t      f,
  output date_t     date
);

  side_t side_r [3:7];

  logic [4:0]  era3_nxt;
  logic [4:0]  era_r [3:7];
  logic [17:0] doe3_r, doe3_nxt;

  logic [35:0] p1460_4_r, p36524_4_r;
  logic [17:0] doe4_r;

  logic [17:0] num5;
  logic [35:0] np5_r;
  logic [17:0] doe5_r;

  logic [8:0]  yoe6_nxt;
  logic [8:0]  yoe6_r;
  logic [17:0] y365_6_r;
  logic [18:0] py100_6_r;
  logic [17:0] doe6_r;

  logic [8:0]  doy7_nxt;
  logic [10:0] x7;
  logic [8:0]  doy7_r;
  logic [22:0] mp7_r;
  logic [8:0]  yoe7_r;

  logic [3:0]  mp8;
  month_t      mm8;
  day_t        dd8;
  year_t       yy8;
  date_t       date_nxt;
  date_t       date_r;

  always_comb begin
    era3_nxt = f.ep[ERA_SH +: 5];
    doe3_nxt = 18'(f.zp - 22'(era3_nxt) * 22'(ERA_DAYS));
  end

  // Year of era: corrects for leap days at 4, 100 and 400 year spacing.
  always_comb begin
    num5 = doe4_r - 18'(p1460_4_r[D1460_SH +: 7]) + 18'(p36524_4_r[D36524_SH +: 3])
         - 18'(doe4_r == DOE_LAST);
  end

  assign yoe6_nxt = np5_r[D365_SH +: 9];

  always_comb begin
    doy7_nxt = 9'(doe6_r - (y365_6_r + 18'(yoe6_r >> 2) - 18'(py100_6_r[YOE100_SH +: 2])));
    x7       = 11'(doy7_nxt) * 11'(5) + 11'(2);
  end

  always_comb begin
    mp8 = mp7_r[MP_SH +: 4];
    dd8 = 5'(doy7_r + 9'd1 - day_offset(mp8 + 4'd3));
    mm8 = (mp8 < 4'd10) ? mp8 + 4'd3 : mp8 - 4'd9;
    yy8 = 14'(era_r[7]) * 14'(400) + 14'(yoe7_r) + 14'(mm8 <= 4'd2);
    priority if (side_r[7].nocarry) begin
      date_nxt.year  = side_r[7].sy;
      date_nxt.month = side_r[7].sm;
      date_nxt.day   = side_r[7].sd;
    end else if (side_r[7].sat_hi) begin
      date_nxt.year  = YEAR_MAX;
      date_nxt.month = MONTH_MAX;
      date_nxt.day   = DAY_MAX;
    end else if (side_r[7].sat_lo) begin
      date_nxt.year  = YEAR_MIN;
      date_nxt.month = MONTH_MIN;
      date_nxt.day   = DAY_MIN;
    end else begin
      date_nxt.year  = yy8;
      date_nxt.month = mm8;
      date_nxt.day   = dd8;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      side_r[3] <= f.side;
      era_r[3]  <= era3_nxt;
      doe3_r    <= doe3_nxt;
    end
    for (int i = 4; i <= 7; i++) begin
      if (ctl.en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
    for (int i = 4; i <= 7; i++) begin
      if (ctl.en[i]) begin
        era_r[i] <= era_r[i-1];
      end
    end
    if (ctl.en[4]) begin
      p1460_4_r  <= 36'(doe3_r) * 36'(D1460_K);
      p36524_4_r <= 36'(doe3_r) * 36'(D36524_K);
      doe4_r     <= doe3_r;
    end
    if (ctl.en[5]) begin
      np5_r  <= 36'(num5) * 36'(D365_K);
      doe5_r <= doe4_r;
    end
    if (ctl.en[6]) begin
      yoe6_r    <= yoe6_nxt;
      y365_6_r  <= 18'(yoe6_nxt) * 18'(365);
      py100_6_r <= 19'(yoe6_nxt) * 19'(YOE100_K);
      doe6_r    <= doe5_r;
    end
    if (ctl.en[7]) begin
      doy7_r <= doy7_nxt;
      mp7_r  <= 23'(x7) * 23'(MP_K);
      yoe7_r <= yoe6_r;
    end
    if (ctl.en[8]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

@@ src/event_end_datetime_calc_top.sv @@
// Top level of the event end date and time calculator.
//
//   Channel   Dir  Handshake    Word contents
//   in_chan   in   valid/ready  start date, start minute, duration, color
//   out_chan  out  valid/ready  start hour/minute, end date, end hour/minute
//
// One word is taken per cycle unless a stalled output has backed up the pipeline;
// a result passes through the nine register stages of the pipeline, the first
// of which loads at the accepting edge.
// Events with the deleted color are accepted and leave no result.
// Reset clears only the stage valid bits.
// A stalled output holds its word; upstream stages keep filling empty slots.
module event_end_datetime_calc_top import edc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  edc_in_if.sink   in_chan,
  edc_out_if.source out_chan
);

  pipe_ctl_t  ctl;
  logic       out_valid;
  logic       in_ready;
  logic [4:0] carry;
  time_res_t  tres;
  fwd_t       fwd;
  date_t      date;

  edc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_live   (in_chan.event_color != DELETED_COLOR),
    .out_ready (out_chan.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  edc_time u_time (
    .clk   (clk),
    .ctl   (ctl),
    .smin  (in_chan.start_minute_of_day),
    .dur   (in_chan.duration_minutes),
    .carry (carry),
    .res   (tres)
  );

  edc_fwd u_fwd (
    .clk   (clk),
    .ctl   (ctl),
    .sy    (in_chan.start_year),
    .sm    (in_chan.start_month),
    .sd    (in_chan.start_day),
    .carry (carry),
    .f     (fwd)
  );

  edc_inv u_inv (
    .clk  (clk),
    .ctl  (ctl),
    .f    (fwd),
    .date (date)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.begin_hour   = tres.begin_hour;
  assign out_chan.begin_minute = tres.begin_minute;
  assign out_chan.end_year     = date.year;
  assign out_chan.end_month    = date.month;
  assign out_chan.end_day      = date.day;
  assign out_chan.end_hour     = tres.end_hour;
  assign out_chan.end_minute   = tres.end_minute;

endmodule

@@ tb/sv/edc_tb_pkg.sv @@
// Event and result word types plus the result word scoreboard for the calculator testbench.
`timescale 1ns / 100ps
package edc_tb_pkg;
  import edc_pkg::*;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
    mod_t   minute;
    dur_t   duration;
    color_t color;
  } cal_event_t;

  typedef struct packed {
    hour_t   begin_hour;
    minute_t begin_minute;
    year_t   end_year;
    month_t  end_month;
    day_t    end_day;
    hour_t   end_hour;
    minute_t end_minute;
  } event_span_t;

  localparam longint DAY_LEN    = 1440;
  localparam longint HOUR_LEN   = 60;
  localparam longint EPOCH_JDN  = 1721425;
  localparam longint JDN_SHIFT  = 68569;
  localparam longint ERA_LEN    = 146097;
  localparam longint QUAD_CENT  = 1461001;
  localparam longint MONTH_DIV  = 2447;
  localparam longint MAR_BIAS   = 306;
  localparam longint MONTH_BASE = 457;
  localparam longint PAD_YEARS  = 400;
  localparam longint LAST_YEAR  = 9999;

  class end_time_tracker;
    event_span_t pending_spans[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint days_from_date(longint y, longint m, longint d);
      longint yy;
      if (m < 3) begin
        y -= 1;
        m += 12;
      end
      yy = y + PAD_YEARS;
      return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * m - MONTH_BASE) / 5
             + d - MAR_BIAS - ERA_LEN;
    endfunction

    static function void date_from_days(longint dn, output longint y, output longint m,
                                        output longint d);
      longint l, n, i, j;
      l = dn + EPOCH_JDN + JDN_SHIFT;
      n = (4 * l) / ERA_LEN;
      l = l - (ERA_LEN * n + 3) / 4;
      i = (4000 * (l + 1)) / QUAD_CENT;
      l = l - (1461 * i) / 4 + 31;
      j = (80 * l) / MONTH_DIV;
      d = l - (MONTH_DIV * j) / 80;
      l = j / 11;
      m = j + 2 - 12 * l;
      y = 100 * (n - 49) + i + l;
    endfunction

    function event_span_t predict_span(cal_event_t ev);
      longint total, carry, eod, s, y, m, d;
      event_span_t r;
      total = longint'(ev.minute) + longint'(ev.duration);
      carry = total / DAY_LEN;
      eod = total % DAY_LEN;
      s = longint'(ev.minute) % DAY_LEN;
      r.end_year = ev.year;
      r.end_month = ev.month;
      r.end_day = ev.day;
      if (carry > 0) begin
        date_from_days(days_from_date(ev.year, ev.month, ev.day) + carry, y, m, d);
        if (y > LAST_YEAR) begin
          r.end_year = YEAR_MAX;
          r.end_month = MONTH_MAX;
          r.end_day = DAY_MAX;
        end else if (y < 1) begin
          r.end_year = YEAR_MIN;
          r.end_month = MONTH_MIN;
          r.end_day = DAY_MIN;
        end else begin
          r.end_year = year_t'(y);
          r.end_month = month_t'(m);
          r.end_day = day_t'(d);
        end
      end
      r.begin_hour = hour_t'(s / HOUR_LEN);
      r.begin_minute = minute_t'(s % HOUR_LEN);
      r.end_hour = hour_t'(eod / HOUR_LEN);
      r.end_minute = minute_t'(eod % HOUR_LEN);
      return r;
    endfunction

    function void note_event(cal_event_t ev);
      if (ev.color != DELETED_COLOR) pending_spans.push_back(predict_span(ev));
    endfunction

    function void compare_field(string name, logic [13:0] want, logic [13:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_span(event_span_t got);
      event_span_t want;
      if (pending_spans.size() == 0) begin
        $error("result word with no event pending: %p", got);
        mismatches++;
        return;
      end
      want = pending_spans.pop_front();
      compare_field("begin_hour", 14'(want.begin_hour), 14'(got.begin_hour));
      compare_field("begin_minute", 14'(want.begin_minute), 14'(got.begin_minute));
      compare_field("end_year", want.end_year, got.end_year);
      compare_field("end_month", 14'(want.end_month), 14'(got.end_month));
      compare_field("end_day", 14'(want.end_day), 14'(got.end_day));
      compare_field("end_hour", 14'(want.end_hour), 14'(got.end_hour));
      compare_field("end_minute", 14'(want.end_minute), 14'(got.end_minute));
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction
  endclass

endpackage

@@ tb/sv/event_end_datetime_calc_top_tb.sv @@
// Top-level testbench for the event end date and time calculator.
`timescale 1ns / 100ps
module event_end_datetime_calc_top_tb;
  import edc_pkg::*;
  import edc_tb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 300;

  logic clk;
  logic rst_n;
  int send_idle;
  int recv_idle;
  int quiet_cycles;
  end_time_tracker spans;
  event_span_t out_word;

  edc_in_if in_chan();
  edc_out_if out_chan();

  event_end_datetime_calc_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  assign out_word = {out_chan.begin_hour, out_chan.begin_minute, out_chan.end_year,
                     out_chan.end_month, out_chan.end_day, out_chan.end_hour,
                     out_chan.end_minute};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) spans.check_span(out_word);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  function automatic cal_event_t make_event(int y, int m, int d, int mins, int dur,
                                            int color);
    cal_event_t ev;
    ev.year = year_t'(y);
    ev.month = month_t'(m);
    ev.day = day_t'(d);
    ev.minute = mod_t'(mins);
    ev.duration = dur_t'(dur);
    ev.color = color_t'(color);
    return ev;
  endfunction

  task automatic send_event(cal_event_t ev);
    while ($urandom_range(0, 99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.start_year <= ev.year;
    in_chan.start_month <= ev.month;
    in_chan.start_day <= ev.day;
    in_chan.start_minute_of_day <= ev.minute;
    in_chan.duration_minutes <= ev.duration;
    in_chan.event_color <= ev.color;
    do @(posedge clk); while (!in_chan.ready);
    spans.note_event(ev);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (spans.pending() > 0) @(posedge clk);
    repeat (NSTG + 2) @(negedge clk);
  endtask

  task automatic random_events(int count);
    cal_event_t ev;
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) ev.year = year_t'($urandom_range(1, 9999));
      else if (pick == 7) ev.year = year_t'($urandom_range(9990, 9999));
      else if (pick == 8) ev.year = year_t'($urandom_range(0, 3));
      else ev.year = year_t'($urandom);
      ev.month = ($urandom_range(0, 9) < 9) ? month_t'($urandom_range(1, 12))
                                            : month_t'($urandom);
      ev.day = ($urandom_range(0, 9) < 9) ? day_t'($urandom_range(1, 31)) : day_t'($urandom);
      ev.minute = ($urandom_range(0, 9) < 9) ? mod_t'($urandom_range(0, 1439))
                                             : mod_t'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) ev.duration = dur_t'($urandom_range(0, 1439));
      else if (pick < 5) ev.duration = dur_t'(DAY_LEN - ev.minute % DAY_LEN - 1
                                              + $urandom_range(0, 2));
      else if (pick < 6) ev.duration = dur_t'($urandom_range(32700, 32767));
      else ev.duration = dur_t'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) ev.color = DELETED_COLOR;
      else if (pick == 1) ev.color = color_t'($urandom_range(0, 3));
      else ev.color = color_t'($urandom);
      send_event(ev);
      sent++;
    end
  endtask

  initial begin
    spans = new();
    rst_n = 1'b0;
    send_idle = 26;
    recv_idle = 65;
    in_chan.valid = 1'b0;
    in_chan.start_year = '0;
    in_chan.start_month = '0;
    in_chan.start_day = '0;
    in_chan.start_minute_of_day = '0;
    in_chan.duration_minutes = '0;
    in_chan.event_color = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_event(make_event(0, 0, 0, 0, 0, 0));
    send_event(make_event(16383, 15, 31, 2047, 32767, 2147483647));
    send_event(make_event(2024, 6, 15, 600, 90, 2));
    send_event(make_event(2024, 6, 15, 600, 90, 3));
    send_event(make_event(2023, 2, 30, 0, 10, 1));
    send_event(make_event(2024, 2, 29, 1439, 0, 5));
    send_event(make_event(2023, 12, 31, 1439, 1, 7));
    send_event(make_event(2024, 2, 28, 720, 1440, 9));
    send_event(make_event(1900, 2, 28, 0, 1440, 11));
    send_event(make_event(2000, 2, 28, 0, 1440, 13));
    send_event(make_event(2000, 3, 1, 1440, 0, 15));
    send_event(make_event(2000, 3, 1, 2047, 0, 17));
    send_event(make_event(2001, 0, 15, 0, 1440, 19));
    send_event(make_event(2001, 13, 1, 0, 1440, 21));
    send_event(make_event(2001, 15, 31, 0, 1440, 23));
    send_event(make_event(2001, 3, 0, 0, 1440, 25));
    send_event(make_event(2001, 2, 31, 0, 1440, 27));
    send_event(make_event(0, 1, 1, 0, 1440, 29));
    send_event(make_event(0, 3, 1, 0, 1440, 31));
    send_event(make_event(9999, 12, 31, 0, 1440, 33));
    send_event(make_event(9999, 12, 30, 0, 1440, 35));
    send_event(make_event(1, 1, 1, 0, 0, 0));
    send_event(make_event(2020, 1, 1, 1439, 32767, 123456));
    send_event(make_event(9999, 12, 31, 1439, 0, 0));
    send_event(make_event(12345, 5, 5, 100, 100, 1048576));
    drain_results();

    random_events(RANDOM_PER_PHASE);
    drain_results();
    send_idle = 65;
    recv_idle = 26;
    random_events(RANDOM_PER_PHASE);
    drain_results();
    send_idle = 0;
    recv_idle = 0;
    random_events(RANDOM_PER_PHASE);
    drain_results();

    if (spans.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
